// ----- hdl/nga_pkg.sv -----
// Package for the stereo noise gate: widths, reset values, register indexes
// and the sequencer state type. No dependencies.
`default_nettype none
package nga_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int TIMER_BITS  = 16;
  localparam int GAIN_BITS   = 16;
  localparam int THR_BITS    = 15;
  localparam int CFG_BITS    = 16;
  localparam int IDX_BITS    = 2;
  localparam int FRAC_BITS   = 15;
  // quotient of a ramp step is below the gain span, so it fits in GAIN_BITS
  localparam int DIV_STEPS   = GAIN_BITS;
  localparam int MUL_BITS    = 18;
  localparam int PROD_BITS   = 2 * MUL_BITS;

  localparam logic [GAIN_BITS-1:0]   UNITY_GAIN    = 16'd32768;
  localparam logic [THR_BITS-1:0]    THRESHOLD_RST = 15'd23197;
  localparam logic [TIMER_BITS-1:0]  ATTACK_RST    = 16'd22050;
  localparam logic [TIMER_BITS-1:0]  RELEASE_RST   = 16'd22050;
  localparam logic [GAIN_BITS-1:0]   FLOOR_RST     = 16'd32768;

  localparam logic [IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_ATTACK    = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_RELEASE   = 2'd2;
  localparam logic [IDX_BITS-1:0] REG_FLOOR     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MUL_RAMP,
    ST_DIV_LOAD,
    ST_DIV,
    ST_MUL_GAIN,
    ST_SAT,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ----- hdl/noise_gate_attack_release.sv -----
// Stereo noise gate with linear attack and release gain ramps.
// Depends on nga_pkg for widths, register indexes and the state type.
`default_nettype none

// One frame (left, then right sample) is taken per transaction and gives one
// result transaction. A single 18x18 multiplier and a one-bit-per-cycle
// restoring divider do all arithmetic under a small sequencer. A sample that
// needs a ramp step goes through gate decision, ramp product, divider load,
// 16 divider steps, gain product and saturation; any other sample goes through
// gate decision, gain product and saturation only. A frame is accepted, its two
// samples are worked in turn, and the result goes to the output register.
// s_tready is high only while no frame is in work; a finished frame may wait
// in the output register while the next one is taken.
module noise_gate_attack_release (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [2*nga_pkg::SAMPLE_BITS-1:0] s_tdata,  // left_sample, right_sample
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [2*nga_pkg::SAMPLE_BITS-1:0]      m_tdata,  // left_out, right_out
  input  wire logic                              cfg_we,
  input  wire logic [nga_pkg::IDX_BITS-1:0]      cfg_index,
  input  wire logic [nga_pkg::CFG_BITS-1:0]      cfg_data
);
  import nga_pkg::*;

  state_t state, state_next;

  logic [THR_BITS-1:0]   threshold_level;
  logic [TIMER_BITS-1:0] attack_length;
  logic [TIMER_BITS-1:0] release_length;
  logic [GAIN_BITS-1:0]  floor_gain;

  logic                  gate_open;
  logic [TIMER_BITS-1:0] ramp_timer;

  logic [SAMPLE_BITS-1:0] left_in, right_in, left_res, right_res;
  logic                   chan;
  logic                   ramp_up;
  logic [TIMER_BITS-1:0]  divisor;
  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod;
  logic [GAIN_BITS-1:0]   div_rem;
  logic [GAIN_BITS-1:0]   div_dvd;
  logic [GAIN_BITS-1:0]   div_quo;
  logic [$clog2(DIV_STEPS)-1:0] div_cnt;

  logic [SAMPLE_BITS-1:0]  cur_sample;
  logic signed [SAMPLE_BITS:0] cur_ext;
  logic [SAMPLE_BITS:0]    mag;
  logic                    below;
  logic [GAIN_BITS-1:0]    flr;
  logic [GAIN_BITS-1:0]    span;
  logic [GAIN_BITS:0]      trial;
  logic [GAIN_BITS:0]      diff;
  logic                    fits;
  logic [GAIN_BITS-1:0]    quo_fin;
  logic [GAIN_BITS-1:0]    ramp_gain;
  logic signed [PROD_BITS-FRAC_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0]  sat_val;

  localparam logic signed [PROD_BITS-FRAC_BITS-1:0] SAT_MAX =
    (PROD_BITS-FRAC_BITS)'((1 << (SAMPLE_BITS-1)) - 1);
  localparam logic signed [PROD_BITS-FRAC_BITS-1:0] SAT_MIN =
    -(PROD_BITS-FRAC_BITS)'(1 << (SAMPLE_BITS-1));

  always_comb begin
    cur_sample = chan ? right_in : left_in;
    cur_ext    = $signed({cur_sample[SAMPLE_BITS-1], cur_sample});
    mag        = cur_ext[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-cur_ext) : cur_ext;
    below      = mag < (SAMPLE_BITS+1)'(threshold_level);
    flr        = (floor_gain > UNITY_GAIN) ? UNITY_GAIN : floor_gain;
    span       = UNITY_GAIN - flr;
    // one restoring divider step
    trial      = {div_rem, div_dvd[GAIN_BITS-1]};
    diff       = trial - {1'b0, divisor};
    fits       = trial >= {1'b0, divisor};
    quo_fin    = {div_quo[GAIN_BITS-2:0], fits};
    ramp_gain  = ramp_up ? (flr + quo_fin) : (UNITY_GAIN - quo_fin);
    // drop fraction bits (floor), then clip to the sample range
    scaled     = prod[PROD_BITS-1:FRAC_BITS];
    if (scaled > SAT_MAX) begin
      sat_val = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_MIN) begin
      sat_val = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat_val = scaled[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_MUL_GAIN;
        if (below && !gate_open && ramp_timer < attack_length) begin
          state_next = ST_MUL_RAMP;
        end else if (!below && gate_open && ramp_timer != '0 &&
                     ramp_timer < release_length) begin
          state_next = ST_MUL_RAMP;
        end
      end
      ST_MUL_RAMP: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) state_next = ST_MUL_GAIN;
      end
      ST_MUL_GAIN: state_next = ST_SAT;
      ST_SAT:      state_next = chan ? ST_DONE : ST_DECIDE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_level <= THRESHOLD_RST;
      attack_length   <= ATTACK_RST;
      release_length  <= RELEASE_RST;
      floor_gain      <= FLOOR_RST;
      gate_open       <= 1'b1;
      ramp_timer      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: threshold_level <= cfg_data[THR_BITS-1:0];
          REG_ATTACK:    attack_length   <= cfg_data[TIMER_BITS-1:0];
          REG_RELEASE:   release_length  <= cfg_data[TIMER_BITS-1:0];
          REG_FLOOR:     floor_gain      <= cfg_data[GAIN_BITS-1:0];
          default: ;
        endcase
      end

      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          left_in  <= s_tdata[SAMPLE_BITS-1:0];
          right_in <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
          chan     <= 1'b0;
        end
        ST_DECIDE: begin
          if (below) begin
            if (gate_open) begin
              gate_open  <= 1'b0;
              ramp_timer <= '0;
              mul_a      <= MUL_BITS'(cur_ext);
              mul_b      <= MUL_BITS'(UNITY_GAIN);
            end else if (ramp_timer < attack_length) begin
              // ramp down: unity - span*timer/attack
              mul_a      <= MUL_BITS'(span);
              mul_b      <= MUL_BITS'(ramp_timer);
              divisor    <= attack_length;
              ramp_up    <= 1'b0;
              ramp_timer <= ramp_timer + 1'b1;
            end else begin
              mul_a <= MUL_BITS'(cur_ext);
              mul_b <= MUL_BITS'(flr);
            end
          end else begin
            if (!gate_open) begin
              gate_open  <= 1'b1;
              ramp_timer <= release_length;
              mul_a      <= MUL_BITS'(cur_ext);
              mul_b      <= MUL_BITS'(flr);
            end else if (ramp_timer != '0) begin
              if (ramp_timer < release_length) begin
                // ramp up: floor + span*(release-timer)/release
                mul_a   <= MUL_BITS'(span);
                mul_b   <= MUL_BITS'(release_length - ramp_timer);
                divisor <= release_length;
                ramp_up <= 1'b1;
              end else begin
                mul_a <= MUL_BITS'(cur_ext);
                mul_b <= MUL_BITS'(flr);
              end
              ramp_timer <= ramp_timer - 1'b1;
            end else begin
              mul_a <= MUL_BITS'(cur_ext);
              mul_b <= MUL_BITS'(UNITY_GAIN);
            end
          end
        end
        ST_MUL_RAMP: prod <= mul_a * mul_b;
        ST_DIV_LOAD: begin
          // quotient fits GAIN_BITS, so the high half is already below the divisor
          div_rem <= prod[2*GAIN_BITS-1:GAIN_BITS];
          div_dvd <= prod[GAIN_BITS-1:0];
          div_quo <= '0;
          div_cnt <= '0;
        end
        ST_DIV: begin
          div_rem <= fits ? diff[GAIN_BITS-1:0] : trial[GAIN_BITS-1:0];
          div_dvd <= {div_dvd[GAIN_BITS-2:0], 1'b0};
          div_quo <= quo_fin;
          div_cnt <= div_cnt + 1'b1;
          mul_a   <= MUL_BITS'(cur_ext);
          mul_b   <= MUL_BITS'(ramp_gain);
        end
        ST_MUL_GAIN: prod <= mul_a * mul_b;
        ST_SAT: begin
          // hold both results until the output register is free
          if (chan) begin
            right_res <= sat_val;
          end else begin
            left_res <= sat_val;
          end
          chan <= 1'b1;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {right_res, left_res};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_noise_gate_attack_release.sv -----
// Self-checking testbench for the stereo noise gate: directed and random frames
// are checked against a cycle-free gain predictor kept in a small tracker class.
// Depends on nga_pkg and noise_gate_attack_release.
`default_nettype none

class gate_tracker;
  logic [14:0] thr;
  logic [15:0] atk;
  logic [15:0] rel;
  logic [15:0] flr;
  bit          gate_open;
  logic [15:0] ramp;
  logic [31:0] expected_frames[$];
  int          errors;

  function new();
    thr       = nga_pkg::THRESHOLD_RST;
    atk       = nga_pkg::ATTACK_RST;
    rel       = nga_pkg::RELEASE_RST;
    flr       = nga_pkg::FLOOR_RST;
    gate_open = 1'b1;
    ramp      = '0;
    errors    = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] v);
    case (idx)
      nga_pkg::REG_THRESHOLD: thr = v[14:0];
      nga_pkg::REG_ATTACK:    atk = v;
      nga_pkg::REG_RELEASE:   rel = v;
      nga_pkg::REG_FLOOR:     flr = v;
      default: ;
    endcase
  endfunction

  // Gain selection and timer update for one sample, then scale and saturate.
  function logic [15:0] gated_sample(logic signed [15:0] s);
    longint mag, fl, span, gain, p, q;
    mag  = (s < 0) ? -longint'(s) : longint'(s);
    fl   = (flr > nga_pkg::UNITY_GAIN) ? 32768 : longint'(flr);
    span = 32768 - fl;
    if (mag < longint'(thr)) begin
      if (gate_open) begin
        gate_open = 1'b0;
        ramp      = '0;
        gain      = 32768;
      end else if (ramp < atk) begin
        gain = 32768 - (span * longint'(ramp)) / longint'(atk);
        ramp = ramp + 16'd1;
      end else begin
        gain = fl;
      end
    end else begin
      if (!gate_open) begin
        gate_open = 1'b1;
        ramp      = rel;
        gain      = fl;
      end else if (ramp != 0) begin
        if (ramp >= rel) gain = fl;
        else gain = fl + (span * longint'(rel - ramp)) / longint'(rel);
        ramp = ramp - 16'd1;
      end else begin
        gain = 32768;
      end
    end
    p = longint'(s) * gain;
    q = p >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Left is gated before right; both share the open flag and the timer.
  function void note_frame(logic [31:0] d);
    logic [15:0] l, r;
    l = gated_sample(d[15:0]);
    r = gated_sample(d[31:16]);
    expected_frames.push_back({r, l});
  endfunction

  function int pending();
    return expected_frames.size();
  endfunction

  task report(string msg);
    if (errors < 40) $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_frame(logic [31:0] got);
    logic [31:0] want;
    if (expected_frames.size() == 0) begin
      report($sformatf("result %h with nothing expected", got));
      return;
    end
    want = expected_frames.pop_front();
    if (got[15:0] !== want[15:0])
      report($sformatf("left_out %h, expected %h", got[15:0], want[15:0]));
    if (got[31:16] !== want[31:16])
      report($sformatf("right_out %h, expected %h", got[31:16], want[31:16]));
  endtask
endclass

module tb_noise_gate_attack_release;
  import nga_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // left_sample, right_sample
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // left_out, right_out
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  gate_tracker sb;
  bit          steady = 1'b0;
  int          sink_hold = 0;
  int          stall_cycles = 0;

  noise_gate_attack_release dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit src_gap();
    return !steady && ($urandom_range(99) < 15);
  endfunction

  // Pick a sample below or at/above the threshold, hitting the boundary now and then.
  function automatic logic [15:0] pick_sample(bit loud_in, logic [14:0] thr);
    int unsigned mag;
    int unsigned thr32;
    bit          loud;
    logic [15:0] m16;
    thr32 = {17'd0, thr};
    loud = loud_in || (thr == 0);
    if (loud) mag = ($urandom_range(9) == 0) ? thr32 : $urandom_range(32768, thr32);
    else mag = ($urandom_range(9) == 0) ? thr32 - 1 : $urandom_range(thr32 - 1, 0);
    if (mag == 32768) return 16'h8000;
    m16 = mag[15:0];
    return $urandom_range(1) ? -m16 : m16;
  endfunction

  task automatic send_frame(input logic [31:0] d);
    while (src_gap()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_frame(d);
  endtask

  task automatic send_frames(input logic [31:0] list[$]);
    foreach (list[i]) send_frame(list[i]);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic configure(input logic [14:0] thr, input logic [15:0] atk,
                           input logic [15:0] rel, input logic [15:0] flr);
    write_reg(REG_THRESHOLD, {1'b0, thr});
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_FLOOR, flr);
    cfg_we <= 1'b0;
  endtask

  // Receiver: random back-pressure, or a long hold-off when requested.
  initial forever begin
    @(posedge clk);
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // Check results and watch for a hung handshake.
  always @(posedge clk) begin
    if (m_tvalid && m_tready) sb.check_frame(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] frames[$];
    logic [14:0] thr;
    logic [15:0] atk, rel, flr, l, r;
    int          run_left;
    bit          loud;

    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: zero, full scale, smallest codes, threshold boundary.
    frames = '{32'h0000_0000, {16'h8000, 16'h7FFF}, {16'h0001, 16'hFFFF},
               {16'hA563, 16'h5A9D}, {16'hA564, 16'h5A9C}};
    send_frames(frames);

    // Short ramps to a zero floor: attack to the floor, then release.
    wait_idle();
    configure(15'd1000, 16'd4, 16'd6, 16'd0);
    frames = '{{16'hFF38, 16'h00C8}, {16'hFF38, 16'h00C8}, {16'h0000, 16'hFF38},
               {16'h7000, 16'h9000}};
    send_frames(frames);

    // Shrink the release while the timer is past it.
    wait_idle();
    configure(15'd1000, 16'd4, 16'd2, 16'd0);
    frames = '{{16'h7000, 16'h9000}, {16'h8000, 16'h03E8}, {16'hFC18, 16'h7FFF},
               {16'hFF38, 16'h00C8}, {16'h7000, 16'h9000}};
    send_frames(frames);

    // Release length of zero with the timer still running.
    wait_idle();
    configure(15'd1000, 16'd4, 16'd0, 16'd0);
    frames = '{{16'h7000, 16'h9000}, {16'h1000, 16'hF000}};
    send_frames(frames);

    // Zero attack, floor above unity.
    wait_idle();
    configure(15'd500, 16'd0, 16'd1, 16'hFFFF);
    frames = '{{16'h0000, 16'h01F3}, {16'hFE0D, 16'h0001}, {16'h01F4, 16'hFE0C}};
    send_frames(frames);

    // Zero threshold: nothing is quiet.
    wait_idle();
    configure(15'd0, 16'd1, 16'd1, 16'd40000);
    frames = '{32'h0000_0000, {16'h8000, 16'h0001}};
    send_frames(frames);

    // Largest threshold and ramp lengths.
    wait_idle();
    configure(15'h7FFF, 16'hFFFF, 16'hFFFF, 16'd0);
    frames = '{{16'h8000, 16'h7FFF}, {16'h8002, 16'h7FFE}, {16'h1234, 16'hC000},
               {16'h8001, 16'h7FFF}};
    send_frames(frames);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case ($urandom_range(5))
        0:       thr = '0;
        1:       thr = 15'h7FFF;
        default: thr = 15'($urandom_range(12000, 200));
      endcase
      case ($urandom_range(4))
        0:       atk = '0;
        1:       atk = 16'hFFFF;
        default: atk = 16'($urandom_range(24, 1));
      endcase
      case ($urandom_range(4))
        0:       rel = '0;
        1:       rel = 16'hFFFF;
        default: rel = 16'($urandom_range(24, 1));
      endcase
      case ($urandom_range(5))
        0:       flr = '0;
        1:       flr = 16'h8000;
        2:       flr = 16'hFFFF;
        default: flr = 16'($urandom_range(32768, 0));
      endcase
      configure(thr, atk, rel, flr);
      steady = (ph == 3);
      // Hold the output off so the block backs up into its input.
      if (ph == 2) sink_hold = 300;
      run_left = 0;
      loud = 1'b0;
      for (int i = 0; i < 82; i++) begin
        if (run_left == 0) begin
          loud = 1'($urandom_range(1));
          run_left = $urandom_range(12, 1);
        end
        run_left--;
        if ($urandom_range(99) < 15) begin
          send_frame($urandom());
        end else begin
          l = pick_sample(loud ^ ($urandom_range(9) == 0), thr);
          r = pick_sample(loud, thr);
          send_frame({r, l});
        end
      end
      s_tvalid <= 1'b0;
    end
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
